// ===== rtl/sgf_pkg.sv =====
// Package for the sequence gap finder: window geometry, operation and status
// codes, controller states and the item and result records.
// Depends on nothing; sgf_engine, the top level and the bench import it.
package sgf_pkg;

  // Window of remote sequence numbers, kept as WindowBits presence bits.
  localparam int unsigned WindowBits = 8192;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned BitW       = $clog2(WordBits);
  localparam int unsigned Words      = WindowBits / WordBits;
  localparam int unsigned WordAw     = (Words > 1) ? $clog2(Words) : 1;

  localparam logic [WordAw-1:0] LastWord  = WordAw'(Words - 1);
  localparam logic [31:0]       WindowLen = 32'(WindowBits);
  localparam logic [13:0]       CountMax  = 14'h3fff;

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_RECORD   = 2'd1,
    OP_NEXT_GAP = 2'd2,
    OP_DROP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_FRESH     = 3'd0,
    STS_REUSED    = 3'd1,
    STS_TOO_LARGE = 3'd2,
    STS_GAP       = 3'd3,
    STS_NO_MORE   = 3'd4,
    STS_MARKED    = 3'd5,
    STS_IGNORED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_RMW_WR,
    S_SCAN,
    S_RESPOND
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [31:0] query_first;
    logic [31:0] query_last;
    logic [15:0] query_node;
    logic [15:0] entry_mark;
    logic [15:0] entry_node;
    logic [31:0] entry_seq;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] gap_seq;
    logic [13:0] gap_count;
  } result_t;

endpackage

// ===== rtl/sgf_if.sv =====
// Channel interfaces of the sequence gap finder: input items, result items
// and configuration writes. Each carries valid, ready and its payload.
// Depends on nothing.
interface sgf_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] query_first;
  logic [31:0] query_last;
  logic [15:0] query_node;
  logic [15:0] entry_mark;
  logic [15:0] entry_node;
  logic [31:0] entry_seq;

  modport source (
    output valid, operation, query_first, query_last, query_node,
           entry_mark, entry_node, entry_seq,
    input  ready
  );
  modport sink (
    input  valid, operation, query_first, query_last, query_node,
           entry_mark, entry_node, entry_seq,
    output ready
  );
endinterface

interface sgf_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] gap_seq;
  logic [13:0] gap_count;

  modport source (output valid, status, gap_seq, gap_count, input ready);
  modport sink   (input valid, status, gap_seq, gap_count, output ready);
endinterface

interface sgf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_marker;

  modport source (output valid, entry_marker, input ready);
  modport sink   (input valid, entry_marker, output ready);
endinterface

// ===== rtl/sgf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No package dependency.
module sgf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 128
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sgf_engine.sv =====
// Controller and datapath of the sequence gap finder: window registers, the
// sequencer that clears, updates and scans the presence bitmap RAM.
// Depends on sgf_pkg and sgf_ram.
module sgf_engine import sgf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       item_i,
  input  logic [15:0] entry_marker_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  // Position of the lowest set bit, found by halving the word each step.
  function automatic logic [BitW-1:0] first_set(input logic [WordBits-1:0] v);
    logic [WordBits-1:0] w;
    logic [BitW-1:0]     pos;
    int                  half;
    w   = v;
    pos = '0;
    for (int k = BitW - 1; k >= 0; k--) begin
      half = 1 << k;
      if ((w & ({WordBits{1'b1}} >> (WordBits - half))) == '0) begin
        w   = w >> half;
        pos = pos | BitW'(half);
      end
    end
    return pos;
  endfunction

  state_e              state_q, state_d;
  item_t               item_q, item_d;
  result_t             res_q, res_d;
  logic                cache_valid_q, cache_valid_d;
  logic [31:0]         base_q, base_d;
  logic [15:0]         node_q, node_d;
  logic [31:0]         cursor_q, cursor_d;
  logic [31:0]         end_q, end_d;
  logic [13:0]         count_q, count_d;
  logic                active_q, active_d;
  logic [WordAw-1:0]   word_q, word_d;
  logic [BitW-1:0]     lo_q, lo_d;
  logic [WordAw-1:0]   clr_q, clr_d;

  logic                ram_we;
  logic [WordAw-1:0]   ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;

  logic [31:0]         len, first_off, last_off, seq_off, cur_off, end_off;
  logic                fits, reuse, rec_ok, scan_ok;
  logic [WordAw-1:0]   end_word;
  logic [BitW-1:0]     end_bit;
  logic                last_word;
  logic [WordBits-1:0] hi_mask, absent;
  logic                any_gap;
  logic [BitW-1:0]     gap_pos;
  logic [31:0]         gap_off, gap_val;
  logic [13:0]         count_inc;

  sgf_ram #(
    .Width (WordBits),
    .Depth (Words)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Offsets are taken modulo 2^32 against the window base.
  assign len       = item_q.query_last - item_q.query_first + 32'd1;
  assign first_off = item_q.query_first - base_q;
  assign last_off  = item_q.query_last - base_q;
  assign seq_off   = item_q.entry_seq - base_q;
  assign cur_off   = cursor_q - base_q;
  assign end_off   = end_q - base_q;

  assign fits    = (len <= WindowLen);
  assign reuse   = cache_valid_q && (item_q.query_node == node_q) &&
                   (first_off < WindowLen) && (last_off < WindowLen);
  assign rec_ok  = cache_valid_q && (item_q.entry_mark == entry_marker_i) &&
                   (item_q.entry_node == node_q) && (seq_off < WindowLen);
  assign scan_ok = active_q && cache_valid_q;

  // The scan looks at one word per cycle, bits from lo_q up to the search end.
  assign end_word  = WordAw'(end_off >> BitW);
  assign end_bit   = BitW'(end_off);
  assign last_word = (word_q == end_word);
  assign hi_mask   = last_word ? ({WordBits{1'b1}} >> (BitW'(WordBits - 1) - end_bit))
                               : {WordBits{1'b1}};
  assign absent    = ~ram_rdata & ({WordBits{1'b1}} << lo_q) & hi_mask;
  assign any_gap   = |absent;
  assign gap_pos   = first_set(absent);
  assign gap_off   = (32'(word_q) << BitW) | 32'(gap_pos);
  assign gap_val   = base_q + gap_off;
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 14'd1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (item_q.operation)
          OP_BEGIN:    state_d = (fits && !reuse) ? S_CLEAR : S_RESPOND;
          OP_RECORD:   state_d = rec_ok ? S_RMW_WR : S_RESPOND;
          OP_NEXT_GAP: state_d = scan_ok ? S_SCAN : S_RESPOND;
          OP_DROP:     state_d = S_RESPOND;
          default:     state_d = S_RESPOND;
        endcase
      end
      S_CLEAR: begin
        if (clr_q == LastWord) state_d = S_RESPOND;
      end
      S_RMW_WR: state_d = S_RESPOND;
      S_SCAN: begin
        if (any_gap || last_word) state_d = S_RESPOND;
      end
      S_RESPOND: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and RAM port control.
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_RESPOND);
    res_o       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = word_q;
    ram_wdata   = ram_rdata | (WordBits'(1) << lo_q);
    ram_raddr   = word_q;
    unique case (state_q)
      S_EXEC: begin
        ram_raddr = (item_q.operation == OP_RECORD) ? WordAw'(seq_off >> BitW)
                                                    : WordAw'(cur_off >> BitW);
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_RMW_WR: ram_we = 1'b1;
      S_SCAN:   ram_raddr = word_q + WordAw'(1);
      default:  ram_raddr = word_q;
    endcase
  end

  // Datapath updates.
  always_comb begin
    item_d        = item_q;
    res_d         = res_q;
    cache_valid_d = cache_valid_q;
    base_d        = base_q;
    node_d        = node_q;
    cursor_d      = cursor_q;
    end_d         = end_q;
    count_d       = count_q;
    active_d      = active_q;
    word_d        = word_q;
    lo_d          = lo_q;
    clr_d         = clr_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) item_d = item_i;
      end
      S_EXEC: begin
        unique case (item_q.operation)
          OP_BEGIN: begin
            if (!fits) begin
              res_d = '{STS_TOO_LARGE, 32'd0, count_q};
            end else begin
              cursor_d = item_q.query_first;
              end_d    = item_q.query_last;
              active_d = (len != 32'd0);
              count_d  = '0;
              if (reuse) begin
                res_d = '{STS_REUSED, 32'd0, 14'd0};
              end else begin
                base_d        = item_q.query_first;
                node_d        = item_q.query_node;
                cache_valid_d = 1'b1;
                clr_d         = '0;
                res_d         = '{STS_FRESH, 32'd0, 14'd0};
              end
            end
          end
          OP_RECORD: begin
            word_d = WordAw'(seq_off >> BitW);
            lo_d   = BitW'(seq_off);
            res_d  = '{(rec_ok ? STS_MARKED : STS_IGNORED), 32'd0, count_q};
          end
          OP_NEXT_GAP: begin
            word_d = WordAw'(cur_off >> BitW);
            lo_d   = BitW'(cur_off);
            if (!scan_ok) begin
              active_d = 1'b0;
              res_d    = '{STS_NO_MORE, 32'd0, count_q};
            end
          end
          OP_DROP: begin
            cache_valid_d = 1'b0;
            active_d      = 1'b0;
            res_d         = '{STS_NO_MORE, 32'd0, count_q};
          end
          default: res_d = '{STS_NO_MORE, 32'd0, count_q};
        endcase
      end
      S_CLEAR: clr_d = clr_q + WordAw'(1);
      S_SCAN: begin
        if (any_gap) begin
          count_d = count_inc;
          res_d   = '{STS_GAP, gap_val, count_inc};
          if (gap_off == end_off) begin
            active_d = 1'b0;
          end else begin
            cursor_d = gap_val + 32'd1;
          end
        end else if (last_word) begin
          active_d = 1'b0;
          res_d    = '{STS_NO_MORE, 32'd0, count_q};
        end else begin
          word_d = word_q + WordAw'(1);
          lo_d   = '0;
        end
      end
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cache_valid_q <= 1'b0;
      base_q        <= '0;
      node_q        <= '0;
      cursor_q      <= 32'd1;
      end_q         <= '0;
      count_q       <= '0;
      active_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      cache_valid_q <= cache_valid_d;
      base_q        <= base_d;
      node_q        <= node_d;
      cursor_q      <= cursor_d;
      end_q         <= end_d;
      count_q       <= count_d;
      active_q      <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    word_q <= word_d;
    lo_q   <= lo_d;
    clr_q  <= clr_d;
  end

  // One item at a time: no new item while a result is offered.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid_o)
    else $error("input ready while a result is pending");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted item not decoded in the next cycle");

  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && clr_q != LastWord) |=> (state_q == S_CLEAR))
    else $error("bitmap clear sweep cut short");

  a_gap_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == STS_GAP) |-> (res_o.gap_count != 14'd0))
    else $error("gap reported without being counted");

  a_gap_seq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != STS_GAP) |-> (res_o.gap_seq == 32'd0))
    else $error("gap sequence number set on a non-gap result");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_RMW_WR))
    else $error("bitmap written outside clear or update");

endmodule

// ===== rtl/sequence_gap_finder_core.sv =====
// Top level of the sequence gap finder: channel interfaces, the marker
// register, the result output register and the engine.
// Depends on sgf_pkg, sgf_if.sv (interfaces) and sgf_engine.
//
//   Channel   Modport  Moves                        Handshake
//   in_if     sink     one item: operation + args   valid & ready
//   out_if    source   one result: status, gap_seq  valid & ready
//                      and gap_count
//   cfg_if    sink     entry_marker write           valid & ready (ready=1)
//
// Sequence: an item is accepted in the idle state, decoded in the execute state
// and its result handed to the output register from the respond state; the next
// item is taken only once that is done. A record that matches adds a
// read-modify-write step on the bitmap RAM. A begin query that opens a fresh
// window clears the bitmap RAM one 64-bit word per cycle. A next-gap item scans
// one 64-bit word of the RAM per cycle from the cursor to the first absent
// number or the search end.
// Reset: asynchronous, active low; it empties the cache and the search. The
// bitmap RAM holds no defined contents until a fresh window clears it.
// Stalls: the output register lets the next item be taken while a result
// waits on out_if; the engine then holds its finished result until the
// register frees.
module sequence_gap_finder_core import sgf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sgf_item_if.sink     in_if,
  sgf_result_if.source out_if,
  sgf_cfg_if.sink      cfg_if
);

  logic [15:0] entry_marker_q, entry_marker_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  item_t       item;
  logic        eng_ready;
  logic        res_valid;
  result_t     res;
  logic        out_free;

  // The marker register is always ready; the user writes it only while idle, which the block does not enforce.
  assign cfg_if.ready   = 1'b1;
  assign entry_marker_d = (cfg_if.valid) ? cfg_if.entry_marker : entry_marker_q;

  assign item.operation   = op_e'(in_if.operation);
  assign item.query_first = in_if.query_first;
  assign item.query_last  = in_if.query_last;
  assign item.query_node  = in_if.query_node;
  assign item.entry_mark  = in_if.entry_mark;
  assign item.entry_node  = in_if.entry_node;
  assign item.entry_seq   = in_if.entry_seq;
  assign in_if.ready      = eng_ready;

  sgf_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .in_ready_o     (eng_ready),
    .item_i         (item),
    .entry_marker_i (entry_marker_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (out_free),
    .res_o          (res)
  );

  // Output register: loads when empty or being emptied in the same cycle.
  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && out_free) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.status    = out_q.status;
  assign out_if.gap_seq   = out_q.gap_seq;
  assign out_if.gap_count = out_q.gap_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_marker_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      entry_marker_q <= entry_marker_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sequence_gap_finder_core: directed rows, then random query sessions.
// Uses sgf_pkg and the channel interfaces in sgf_if.sv; the expected results come from a
// behavioral copy of the gap finder kept inside this file.
module tb_top;
  import sgf_pkg::*;

  // One planned item. When typed is set, want holds the expected result as written in the
  // directed table; otherwise the expectation is computed when the item is accepted.
  typedef struct packed {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_t;

  localparam int unsigned PhaseItems = 245;
  localparam int unsigned EndPause   = 300;
  localparam int unsigned StallLimit = 4000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sgf_item_if   item_ch ();
  sgf_result_if result_ch ();
  sgf_cfg_if    marker_ch ();

  sequence_gap_finder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (item_ch),
    .out_if (result_ch),
    .cfg_if (marker_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Behavioral copy of the gap finder. It tracks the window, the search and the marker
  // register, and advances once per accepted item.
  // ---------------------------------------------------------------------------------------
  bit [WindowBits-1:0] presence_map;
  bit                  win_valid   = 1'b0;
  logic [31:0]         win_base    = '0;
  logic [15:0]         win_node    = '0;
  logic [31:0]         scan_cursor = 32'd1;
  logic [31:0]         scan_last   = '0;
  bit                  scan_live   = 1'b0;
  logic [13:0]         gap_tally   = '0;
  logic [15:0]         marker_reg  = '0;

  // Offsets are taken modulo 2^32, so the window may wrap past the top of the number space.
  function automatic bit in_window_span(logic [31:0] n);
    return (n - win_base) < WindowLen;
  endfunction

  function automatic result_t track_window(item_t it);
    result_t     r;
    logic [31:0] span;
    logic [31:0] c;
    logic [31:0] off;
    bit          hit;
    int unsigned step;
    r.status  = STS_NO_MORE;
    r.gap_seq = '0;
    hit = 1'b0;
    case (it.operation)
      OP_BEGIN: begin
        span = it.query_last - it.query_first + 32'd1;
        if (span > WindowLen) begin
          // A rejected query leaves every piece of state alone.
          r.status = STS_TOO_LARGE;
        end else begin
          if (win_valid && it.query_node == win_node && in_window_span(it.query_first) &&
              in_window_span(it.query_last)) begin
            r.status = STS_REUSED;
          end else begin
            presence_map = '0;
            win_base     = it.query_first;
            win_node     = it.query_node;
            win_valid    = 1'b1;
            r.status     = STS_FRESH;
          end
          scan_cursor = it.query_first;
          scan_last   = it.query_last;
          scan_live   = (span != 0);
          gap_tally   = '0;
        end
      end
      OP_RECORD: begin
        if (win_valid && it.entry_mark == marker_reg && it.entry_node == win_node &&
            in_window_span(it.entry_seq)) begin
          presence_map[it.entry_seq - win_base] = 1'b1;
          r.status = STS_MARKED;
        end else begin
          r.status = STS_IGNORED;
        end
      end
      OP_NEXT_GAP: begin
        if (scan_live && win_valid) begin
          for (step = 0; step <= WindowBits; step++) begin
            c   = scan_cursor;
            off = c - win_base;
            if (off >= WindowLen || !presence_map[off]) begin
              hit       = 1'b1;
              r.gap_seq = c;
              if (c == scan_last) scan_live = 1'b0;
              else scan_cursor = c + 32'd1;
              break;
            end
            if (c == scan_last) break;
            scan_cursor = c + 32'd1;
          end
        end
        if (hit) begin
          r.status = STS_GAP;
          if (gap_tally < CountMax) gap_tally = gap_tally + 14'd1;
        end else begin
          scan_live = 1'b0;
        end
      end
      default: begin
        win_valid = 1'b0;
        scan_live = 1'b0;
      end
    endcase
    r.gap_count = gap_tally;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Directed rows. The first eleven carry results that follow directly from the rules: the
  // block right after reset, an empty range that spans all 2^32 numbers, a full-size window
  // that wraps across zero, a range one longer than the window, and records at both ends
  // of the window, one past its end and with a wrong marker. The rest walk a search across
  // zero, cache reuse, a search that ends on a present number, an empty range inside the
  // cached window, and a drop, and are checked by the copy above.
  // The marker still holds its reset value of zero here.
  // ---------------------------------------------------------------------------------------
  stim_t opening_rows [26] = '{
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b1,
      '{STS_NO_MORE, 32'h0, 14'h0}},
    '{'{OP_RECORD, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b1,
      '{STS_IGNORED, 32'h0, 14'h0}},
    '{'{OP_DROP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b1,
      '{STS_NO_MORE, 32'h0, 14'h0}},
    '{'{OP_BEGIN, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b1,
      '{STS_FRESH, 32'h0, 14'h0}},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b1,
      '{STS_NO_MORE, 32'h0, 14'h0}},
    '{'{OP_BEGIN, 32'hFFFF_FFFF, 32'h1FFE, 16'hFFFF, 16'h0, 16'h0, 32'h0}, 1'b1,
      '{STS_FRESH, 32'h0, 14'h0}},
    '{'{OP_BEGIN, 32'h0, 32'h2000, 16'hFFFF, 16'h0, 16'h0, 32'h0}, 1'b1,
      '{STS_TOO_LARGE, 32'h0, 14'h0}},
    '{'{OP_RECORD, 32'h0, 32'h0, 16'h0, 16'h0, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
      '{STS_MARKED, 32'h0, 14'h0}},
    '{'{OP_RECORD, 32'h0, 32'h0, 16'h0, 16'h0, 16'hFFFF, 32'h1FFE}, 1'b1,
      '{STS_MARKED, 32'h0, 14'h0}},
    '{'{OP_RECORD, 32'h0, 32'h0, 16'h0, 16'hFFFF, 16'hFFFF, 32'h0}, 1'b1,
      '{STS_IGNORED, 32'h0, 14'h0}},
    '{'{OP_RECORD, 32'h0, 32'h0, 16'h0, 16'h0, 16'hFFFF, 32'h1FFF}, 1'b1,
      '{STS_IGNORED, 32'h0, 14'h0}},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_RECORD, 32'h0, 32'h0, 16'h0, 16'h0, 16'hFFFF, 32'h1}, 1'b0, '0},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_BEGIN, 32'h100, 32'h1FFE, 16'hFFFF, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_BEGIN, 32'h1FFE, 32'h1FFE, 16'hFFFF, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_BEGIN, 32'h5, 32'h4, 16'hFFFF, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_BEGIN, 32'h10, 32'h12, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_RECORD, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h11}, 1'b0, '0},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_DROP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0},
    '{'{OP_NEXT_GAP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0}, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------------------
  // Random item planning. Most of the stimulus is made of sessions: a begin query, records
  // that mostly carry the right marker, node and a number in range, and next-gap items,
  // sometimes closed by a drop. The gen_* variables roughly follow the window the block
  // should hold, so that some queries land inside it and reuse the cache.
  // ---------------------------------------------------------------------------------------
  stim_t       item_plan [$];
  bit          gen_have   = 1'b0;
  logic [31:0] gen_base   = '0;
  logic [15:0] gen_node   = '0;
  logic [15:0] gen_marker = '0;

  // Every field starts fully random so that unused fields toggle all their bits.
  function automatic item_t scrambled_item();
    item_t it;
    it.operation   = op_e'(2'($urandom_range(0, 3)));
    it.query_first = $urandom;
    it.query_last  = $urandom;
    it.query_node  = 16'($urandom);
    it.entry_mark  = 16'($urandom);
    it.entry_node  = 16'($urandom);
    it.entry_seq   = $urandom;
    return it;
  endfunction

  function automatic void queue_item(item_t it);
    stim_t s;
    s.it    = it;
    s.typed = 1'b0;
    s.want  = '0;
    item_plan.push_back(s);
  endfunction

  function automatic void queue_op(op_e op);
    item_t it;
    it = scrambled_item();
    it.operation = op;
    queue_item(it);
  endfunction

  // A record for the given number; now and then the marker or the node is wrong.
  function automatic void plan_record(logic [31:0] seq);
    item_t it;
    it = scrambled_item();
    it.operation = OP_RECORD;
    it.entry_seq = seq;
    if ($urandom_range(0, 11) != 0) it.entry_mark = gen_marker;
    if ($urandom_range(0, 11) != 0) it.entry_node = gen_node;
    queue_item(it);
  endfunction

  function automatic void plan_session();
    item_t       it;
    logic [31:0] first;
    logic [31:0] len;
    logic [15:0] node;
    int unsigned pick;
    int unsigned recs;
    int unsigned asks;
    int unsigned k;
    bit          dense;
    bit          reuse;
    pick  = $urandom_range(0, 19);
    dense = (pick < 3);
    reuse = gen_have && pick >= 3 && pick < 9;
    if (reuse) begin
      node  = gen_node;
      first = gen_base + $urandom_range(0, WindowBits - 200);
      len   = $urandom_range(0, 150);
    end else begin
      node  = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      first = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom;
      if (dense) len = $urandom_range(64, 160);
      else if (pick == 9) len = '0;
      else if (pick == 10 && $urandom_range(0, 1) != 0)
        len = $urandom_range(WindowBits + 1, WindowBits + 64);
      else if (pick == 10) len = $urandom | 32'h0000_4000;
      else if (pick == 11) len = $urandom_range(WindowBits - 8, WindowBits);
      else if (pick == 12) len = $urandom_range(200, WindowBits);
      else len = $urandom_range(1, 60);
    end
    it = scrambled_item();
    it.operation   = OP_BEGIN;
    it.query_first = first;
    it.query_last  = first + len - 32'd1;
    it.query_node  = node;
    queue_item(it);
    if (len > WindowLen) begin
      // A rejected query must leave the old search untouched.
      queue_op(OP_NEXT_GAP);
      return;
    end
    if (!reuse) begin
      gen_have = 1'b1;
      gen_base = first;
      gen_node = node;
    end
    if (dense) begin
      // Nearly every number present: the search has to walk across several words.
      for (k = 0; k < len; k++)
        if ($urandom_range(0, 9) != 0) plan_record(first + k);
      asks = len / 8 + 3;
    end else begin
      recs = $urandom_range(0, 20);
      for (k = 0; k < recs; k++) begin
        case ($urandom_range(0, 9))
          0:       plan_record($urandom);
          1:       plan_record(gen_base + $urandom_range(WindowBits - 4, WindowBits + 3));
          2:       plan_record(gen_base + $urandom_range(0, WindowBits - 1));
          default: plan_record(first + $urandom_range(0, (len != 0) ? len - 1 : 0));
        endcase
      end
      asks = $urandom_range(1, 10);
    end
    for (k = 0; k < asks; k++) begin
      // A record slipped into a running search may land ahead of or behind the cursor.
      if ($urandom_range(0, 4) == 0)
        plan_record(first + $urandom_range(0, (len != 0) ? len - 1 : 0));
      queue_op(OP_NEXT_GAP);
    end
    if ($urandom_range(0, 5) == 0) begin
      queue_op(OP_DROP);
      gen_have = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Item sender, marker writes and the store of expected results.
  // ---------------------------------------------------------------------------------------
  result_t     pending_results [$];
  int unsigned items_sent  = 0;
  int unsigned writes_done = 0;
  int unsigned faults      = 0;

  // Called at a rising edge. The item is accepted at the first later edge that sees ready.
  task automatic offer_item(stim_t s);
    result_t got;
    item_ch.valid       <= 1'b1;
    item_ch.operation   <= s.it.operation;
    item_ch.query_first <= s.it.query_first;
    item_ch.query_last  <= s.it.query_last;
    item_ch.query_node  <= s.it.query_node;
    item_ch.entry_mark  <= s.it.entry_mark;
    item_ch.entry_node  <= s.it.entry_node;
    item_ch.entry_seq   <= s.it.entry_seq;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    got = track_window(s.it);
    pending_results.push_back(s.typed ? s.want : got);
    items_sent++;
  endtask

  task automatic await_drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Sends the planned items in bursts of random length. Between bursts the sender may
  // pause, and once in a while it holds off until every result is back.
  // Valid is lowered only when a pause really follows, so it never drops and rises within
  // one edge.
  task automatic pump_items();
    int unsigned burst;
    int unsigned gap;
    bit          hold;
    while (item_plan.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && item_plan.size() != 0) begin
        offer_item(item_plan.pop_front());
        burst--;
      end
      hold = ($urandom_range(0, 39) == 0);
      gap  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (hold || gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap + hold) @(posedge clk_i);
        if (hold) await_drain();
      end
    end
    item_ch.valid <= 1'b0;
  endtask

  // Only called with no item in flight, so the copy of the register can change at once.
  task automatic set_marker(logic [15:0] value);
    marker_ch.valid        <= 1'b1;
    marker_ch.entry_marker <= value;
    @(posedge clk_i);
    while (!marker_ch.ready) @(posedge clk_i);
    marker_reg = value;
    gen_marker = value;
    writes_done++;
    marker_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Result receiver. Its ready follows a randomly redrawn mode: always ready, coin flips,
  // ready when the tick's low three bits are zero, or alternating stalled and ready runs.
  // ---------------------------------------------------------------------------------------
  initial begin
    logic [31:0] rx_tick;
    int unsigned rx_mode;
    rx_tick = '0;
    rx_mode = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_tick = rx_tick + 32'd1;
      if (rx_tick % 200 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= ($urandom_range(0, 1) != 0);
        2:       result_ch.ready <= (rx_tick[2:0] == 3'd0);
        default: result_ch.ready <= rx_tick[4];
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result checker: each result is held against the oldest expectation, field by field.
  // ---------------------------------------------------------------------------------------
  result_t     head_want;
  int unsigned results_seen = 0;
  int unsigned status_seen [8] = '{default: 0};

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      results_seen++;
      status_seen[result_ch.status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d gap_seq %h gap_count %0d",
                 $time, result_ch.status, result_ch.gap_seq, result_ch.gap_count);
        faults++;
      end else begin
        head_want = pending_results.pop_front();
        if (result_ch.status !== head_want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, head_want.status, result_ch.status);
          faults++;
        end
        if (result_ch.gap_seq !== head_want.gap_seq) begin
          $display("%0t: gap_seq mismatch: expected %h, actual %h",
                   $time, head_want.gap_seq, result_ch.gap_seq);
          faults++;
        end
        if (result_ch.gap_count !== head_want.gap_count) begin
          $display("%0t: gap_count mismatch: expected %0d, actual %0d",
                   $time, head_want.gap_count, result_ch.gap_count);
          faults++;
        end
      end
    end
  end

  // Watchdog: the run is hung if no channel completes a handshake before quiet_cycles reaches StallLimit.
  // A fresh window clear or a full scan stays far below the limit.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (marker_ch.valid && marker_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence: reset, the directed rows with the reset marker, then one random phase
  // per marker setting. The sender waits until every expected result has come back before
  // each phase, so each one starts from an idle block.
  // ---------------------------------------------------------------------------------------
  logic [15:0] phase_markers [6];

  initial begin
    int unsigned phase;
    phase_markers = '{16'hFFFF, 16'($urandom), 16'h0000, 16'($urandom), 16'h8001, 16'hFFFF};
    item_ch.valid          <= 1'b0;
    item_ch.operation      <= '0;
    item_ch.query_first    <= '0;
    item_ch.query_last     <= '0;
    item_ch.query_node     <= '0;
    item_ch.entry_mark     <= '0;
    item_ch.entry_node     <= '0;
    item_ch.entry_seq      <= '0;
    marker_ch.valid        <= 1'b0;
    marker_ch.entry_marker <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[r]) item_plan.push_back(opening_rows[r]);
    pump_items();
    await_drain();

    for (phase = 0; phase < 6; phase++) begin
      set_marker(phase_markers[phase]);
      while (item_plan.size() < PhaseItems) begin
        if ($urandom_range(0, 9) < 7) begin
          plan_session();
        end else begin
          queue_item(scrambled_item());
          if (item_plan[$].it.operation == OP_DROP) gen_have = 1'b0;
        end
      end
      pump_items();
      await_drain();
    end

    // Let any stray result show up before the verdict.
    repeat (EndPause) @(posedge clk_i);
    $display("Covered %0d items under %0d marker writes; %0d results checked, %0d mismatches.",
             items_sent, writes_done, results_seen, faults);
    $display("Seen %0d fresh, %0d reused, %0d too big, %0d gaps, %0d ends, %0d marked, %0d ignored.",
             status_seen[STS_FRESH], status_seen[STS_REUSED], status_seen[STS_TOO_LARGE],
             status_seen[STS_GAP], status_seen[STS_NO_MORE], status_seen[STS_MARKED],
             status_seen[STS_IGNORED]);
    if (faults == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
